// ===== sv/sso_pkg.sv =====
// ----------------------------------------------------------------------------
// sso_pkg
// Shared types and constants for the odd-gap Shell sort block.
// ----------------------------------------------------------------------------
package sso_pkg;

   localparam int DATA_W            = 32;
   localparam int MAX_ITEMS_DEFAULT = 64;

   // controller to datapath
   typedef struct packed {
      logic load;      // store the incoming element, bump the count
      logic gap_init;  // first gap from the count
      logic gap_next;  // halve the gap
      logic rd_i;      // fetch element i
      logic item;      // latch element i, fetch j - gap
      logic shift;     // move j - gap up to j, step j down
      logic place;     // write held element at j, advance i
      logic out_rd;    // fetch element k
      logic out_cap;   // load output register
      logic out_next;  // advance k, clear the set after the last
   } sso_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic close;          // this element closes the set
      logic gap_first_zero; // count/2 is zero
      logic gap_next_zero;  // halved gap is zero
      logic i_end;          // pass over the set finished
      logic greater;        // element at j - gap above held element
      logic j_low;          // no further step down possible
      logic k_last;         // final output element
   } sso_status_type;

endpackage

// ===== sv/sso_ram.sv =====
// ----------------------------------------------------------------------------
// sso_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sso_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sso_dp.sv =====
// ----------------------------------------------------------------------------
// sso_dp
// Datapath: element store, count, gap and index registers, compare, output.
// ----------------------------------------------------------------------------
module sso_dp #(
   parameter int MAX_ITEMS = sso_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sso_pkg::sso_cmd_type         cmd,
   output sso_pkg::sso_status_type      status,
   input  logic [sso_pkg::DATA_W-1:0]   in_value,
   input  logic                         in_last,
   output logic [sso_pkg::DATA_W-1:0]   out_value,
   output logic                         out_last
);
   import sso_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     gap_ff, gap_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [DATA_W-1:0] item_ff, item_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic              out_last_ff, out_last_in;

   logic              wr_en;
   logic [CW-1:0]     wr_idx;
   logic [DATA_W-1:0] wr_data;
   logic [CW-1:0]     rd_idx;
   logic [DATA_W-1:0] rd_data;

   logic [CW-1:0]     half_n;
   logic [CW-1:0]     half_gap;
   logic [CW-1:0]     j_down;

   assign half_n   = n_ff >> 1;
   assign half_gap = gap_ff >> 1;
   assign j_down   = j_ff - gap_ff;

   always_comb begin
      status.close          = in_last || (n_ff + CW'(1) == CW'(MAX_ITEMS));
      status.gap_first_zero = (half_n == '0);
      status.gap_next_zero  = (half_gap == '0);
      status.i_end          = (i_ff >= n_ff);
      status.greater        = ($signed(rd_data) > $signed(item_ff));
      status.j_low          = (j_down < gap_ff);
      status.k_last         = (k_ff + CW'(1) == n_ff);
   end

   always_comb begin
      n_in         = n_ff;
      gap_in       = gap_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      item_in      = item_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      wr_en        = 1'b0;
      wr_idx       = n_ff;
      wr_data      = in_value;
      rd_idx       = '0;

      if (cmd.load) begin
         wr_en = 1'b1;
         n_in  = n_ff + CW'(1);
      end
      if (cmd.gap_init) begin
         gap_in = half_n | CW'(1);
         i_in   = half_n | CW'(1);
      end
      if (cmd.gap_next) begin
         gap_in = half_gap | CW'(1);
         i_in   = half_gap | CW'(1);
      end
      if (cmd.rd_i) begin
         rd_idx = i_ff;
      end
      if (cmd.item) begin
         item_in = rd_data;
         j_in    = i_ff;
         rd_idx  = i_ff - gap_ff;
      end
      if (cmd.shift) begin
         wr_en   = 1'b1;
         wr_idx  = j_ff;
         wr_data = rd_data;
         j_in    = j_down;
         rd_idx  = j_down - gap_ff;
      end
      if (cmd.place) begin
         wr_en   = 1'b1;
         wr_idx  = j_ff;
         wr_data = item_ff;
         i_in    = i_ff + CW'(1);
      end
      if (cmd.out_rd) begin
         rd_idx = k_ff;
      end
      if (cmd.out_cap) begin
         out_value_in = rd_data;
         out_last_in  = status.k_last;
      end
      if (cmd.out_next) begin
         if (status.k_last) begin
            k_in = '0;
            n_in = '0;
         end else begin
            k_in = k_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
         k_ff <= '0;
      end else begin
         n_ff <= n_in;
         k_ff <= k_in;
      end
      gap_ff       <= gap_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      item_ff      <= item_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   sso_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== sv/sso_ctrl.sv =====
// ----------------------------------------------------------------------------
// sso_ctrl
// Controller: sequences loading, the gapped insertion passes and output.
// ----------------------------------------------------------------------------
module sso_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sso_pkg::sso_cmd_type    cmd,
   input  sso_pkg::sso_status_type status
);
   import sso_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_GAP_INIT,
      ST_OUTER,
      ST_ITEM,
      ST_CMP,
      ST_PLACE,
      ST_OUT_RD,
      ST_OUT_CAP,
      ST_OUT_HOLD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               if (status.close) begin
                  state_in = ST_GAP_INIT;
               end
            end
         end
         ST_GAP_INIT: begin
            cmd.gap_init = 1'b1;
            state_in     = status.gap_first_zero ? ST_OUT_RD : ST_OUTER;
         end
         ST_OUTER: begin
            if (status.i_end) begin
               cmd.gap_next = 1'b1;
               state_in     = status.gap_next_zero ? ST_OUT_RD : ST_OUTER;
            end else begin
               cmd.rd_i = 1'b1;
               state_in = ST_ITEM;
            end
         end
         ST_ITEM: begin
            cmd.item = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.greater) begin
               cmd.shift = 1'b1;
               state_in  = status.j_low ? ST_PLACE : ST_CMP;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_OUTER;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_OUTER;
         end
         ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OUT_CAP;
         end
         ST_OUT_CAP: begin
            cmd.out_cap = 1'b1;
            state_in    = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            if (out_ready) begin
               cmd.out_next = 1'b1;
               state_in     = status.k_last ? ST_LOAD : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_ready  = (state_ff == ST_LOAD);
   assign out_valid = (state_ff == ST_OUT_HOLD);

endmodule

// ===== sv/shell_sort_odd_gap.sv =====
// ----------------------------------------------------------------------------
// shell_sort_odd_gap
// Collects a set of signed 32-bit values, sorts it ascending, streams it out.
// ----------------------------------------------------------------------------
// A set is loaded at one transfer per cycle and closes on tlast or when it
// reaches MAX_ITEMS elements. It is then sorted in place by Shell sort with
// gaps count/2, halved each pass and made odd, and emitted in ascending order
// with tlast on the final element, after which a new set is taken. The store
// has one read and one write port, which sets the sort time: each element
// visited in a pass is fetched, latched and compared in turn, with a further
// compare-and-shift step for each element moved up. Output reads, captures
// and then holds each element. Most of the time goes into the sort; no input
// is taken while a set is sorted or emitted.
module shell_sort_odd_gap #(
   parameter int MAX_ITEMS = sso_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [sso_pkg::DATA_W-1:0] req_tdata,  // [31:0] value_in
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [sso_pkg::DATA_W-1:0] rsp_tdata,  // [31:0] value_out
   output logic                       rsp_tlast
);
   import sso_pkg::*;

   sso_cmd_type    cmd;
   sso_status_type status;

   sso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   sso_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_value  (req_tdata),
      .in_last   (req_tlast),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== sim/shell_sort_odd_gap_test.sv =====
// ----------------------------------------------------------------------------
// shell_sort_odd_gap_test
// Self-checking bench for the odd-gap Shell sort block.
// ----------------------------------------------------------------------------
// Input transfers come from a short directed table and then from random sets:
// mostly small sets, some of middling size, and two full sets, one closed by
// the count alone and one with tlast on the 64th element. Values mix the
// extremes, a narrow band that gives many duplicates, and full-range words.
// Each accepted input feeds a local Shell sort of the open set. When the set
// closes, its sorted elements are queued and every output transfer is checked
// against the oldest of them. Both sides idle in random bursts. The output
// side also holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module shell_sort_odd_gap_test;

   localparam int          SET_MAX   = sso_pkg::MAX_ITEMS_DEFAULT;
   localparam int          W         = sso_pkg::DATA_W;
   localparam int unsigned LIMIT     = 400000;
   localparam int unsigned TAIL_ROWS = 40;
   localparam int unsigned HOLD_LEN  = 600;

   typedef struct packed {
      logic [W-1:0] value;
      logic         last;
      logic [1:0]   n_typed;  // results written into the table: 0, 1 or 2
      logic [W-1:0] exp_lo;
      logic [W-1:0] exp_hi;
   } stim_row_type;

   typedef struct packed {
      logic [W-1:0] value;
      logic         last;
   } sorted_elem_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [W-1:0] req_tdata  = '0;  // [31:0] value_in
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [W-1:0] rsp_tdata;        // [31:0] value_out
   logic         rsp_tlast;

   stim_row_type       directed_rows [21];
   stim_row_type       stim_q [$];
   sorted_elem_type    sorted_pending [$];
   logic signed [W-1:0] set_buf [SET_MAX];
   int unsigned        set_len       = 0;
   int unsigned        in_count      = 0;
   int unsigned        send_idx      = 0;
   int unsigned        send_next;
   int unsigned        send_gap      = 0;
   int unsigned        drain_gap     = 0;
   int unsigned        mismatch_count = 0;
   int unsigned        cycle_count   = 0;
   logic               hold_off      = 1'b0;

   shell_sort_odd_gap uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial forever #2 clock = ~clock;

   function automatic bit in_tail();
      in_tail = (in_count + TAIL_ROWS >= stim_q.size());
   endfunction

   function automatic logic [W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: rand_value = 32'h8000_0000;
               1: rand_value = 32'h7FFF_FFFF;
               2: rand_value = 32'h0000_0000;
               default: rand_value = 32'hFFFF_FFFF;
            endcase
         end
         1: rand_value = $urandom_range(0, 8) - 4;
         default: rand_value = $urandom;
      endcase
   endfunction

   // gaps n/2, made odd, halved after each pass
   function automatic void order_set(input int unsigned n);
      int unsigned         gap;
      int unsigned         r;
      int unsigned         i;
      int unsigned         j;
      logic signed [W-1:0] held;
      for (gap = n / 2; gap > 0; gap = gap / 2) begin
         if (gap % 2 == 0) gap++;
         for (r = 0; r < gap; r++) begin
            for (i = r + gap; i < n; i += gap) begin
               held = set_buf[i];
               j = i;
               while (j >= r + gap && set_buf[j - gap] > held) begin
                  set_buf[j] = set_buf[j - gap];
                  j -= gap;
               end
               set_buf[j] = held;
            end
         end
      end
   endfunction

   task automatic predict_set(input logic [W-1:0] v, input logic l, input int unsigned row);
      int unsigned     k;
      sorted_elem_type elem;
      if (set_len >= SET_MAX) set_len = 0;
      set_buf[set_len] = v;
      set_len++;
      if (l || set_len >= SET_MAX) begin
         order_set(set_len);
         case (stim_q[row].n_typed)
            2'd1: begin
               elem = '{value: stim_q[row].exp_lo, last: 1'b1};
               sorted_pending.push_back(elem);
            end
            2'd2: begin
               elem = '{value: stim_q[row].exp_lo, last: 1'b0};
               sorted_pending.push_back(elem);
               elem = '{value: stim_q[row].exp_hi, last: 1'b1};
               sorted_pending.push_back(elem);
            end
            default: begin
               for (k = 0; k < set_len; k++) begin
                  elem = '{value: set_buf[k], last: (k + 1 == set_len)};
                  sorted_pending.push_back(elem);
               end
            end
         endcase
         set_len = 0;
      end
   endtask

   task automatic report(input string field, input logic [W-1:0] want, input logic [W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %h got %h", field, want, got);
   endtask

   initial begin
      stim_row_type row;
      int unsigned  total;
      int unsigned  set_no;
      int unsigned  n;
      int unsigned  k;
      directed_rows = '{
         // single elements at the extremes
         '{32'h0000_0000, 1'b1, 2'd1, 32'h0000_0000, 32'h0},
         '{32'h7FFF_FFFF, 1'b1, 2'd1, 32'h7FFF_FFFF, 32'h0},
         '{32'h8000_0000, 1'b1, 2'd1, 32'h8000_0000, 32'h0},
         '{32'hFFFF_FFFF, 1'b1, 2'd1, 32'hFFFF_FFFF, 32'h0},
         // pairs across the sign boundary
         '{32'h7FFF_FFFF, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h8000_0000, 1'b1, 2'd2, 32'h8000_0000, 32'h7FFF_FFFF},
         '{32'hFFFF_FFFF, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h0000_0001, 1'b1, 2'd2, 32'hFFFF_FFFF, 32'h0000_0001},
         // equal pair
         '{32'h0000_0005, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h0000_0005, 1'b1, 2'd2, 32'h0000_0005, 32'h0000_0005},
         // reversed three
         '{32'h0000_0003, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h0000_0002, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h0000_0001, 1'b1, 2'd0, 32'h0, 32'h0},
         // five with duplicates
         '{32'h0000_0005, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'hFFFF_FFFD, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h0000_0005, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h0000_0000, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'hFFFF_FFFD, 1'b1, 2'd0, 32'h0, 32'h0},
         // alternating bit patterns
         '{32'hAAAA_AAAA, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h5555_5555, 1'b0, 2'd0, 32'h0, 32'h0},
         '{32'h1234_5678, 1'b1, 2'd0, 32'h0, 32'h0}
      };
      foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
      total  = 0;
      set_no = 0;
      while (total < 350) begin
         if (set_no == 4 || set_no == 11)
            n = SET_MAX;
         else if ($urandom_range(0, 3) == 0)
            n = $urandom_range(9, SET_MAX - 1);
         else
            n = $urandom_range(1, 8);
         for (k = 0; k < n; k++) begin
            row.value   = rand_value();
            // set 4 is closed by the count alone
            row.last    = (k + 1 == n) && (set_no != 4);
            row.n_typed = 2'd0;
            row.exp_lo  = '0;
            row.exp_hi  = '0;
            stim_q.push_back(row);
         end
         total += n;
         set_no++;
      end
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_idx   <= 0;
         send_gap   <= 0;
      end else begin
         send_next = send_idx + ((req_tvalid && req_tready) ? 1 : 0);
         send_idx <= send_next;
         if (req_tvalid && !req_tready) begin
         end else if (send_gap != 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (send_next >= stim_q.size()) begin
            req_tvalid <= 1'b0;
         end else if (!in_tail() && $urandom_range(0, 9) == 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= $urandom_range(0, 10);
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= stim_q[send_next].value;
            req_tlast  <= stim_q[send_next].last;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         drain_gap  <= 0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (drain_gap != 0) begin
         rsp_tready <= 1'b0;
         drain_gap  <= drain_gap - 1;
      end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         drain_gap  <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // long output stall while input keeps coming
   initial begin
      wait (in_count >= 120);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_off <= 1'b0;
   end

   // checker: output transfer first, then the input transfer of the same edge
   always @(posedge clock) begin
      sorted_elem_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_pending.size() == 0) begin
               report("no result pending", '0, rsp_tdata);
            end else begin
               want = sorted_pending.pop_front();
               if (rsp_tdata !== want.value) report("value_out", want.value, rsp_tdata);
               if (rsp_tlast !== want.last)
                  report("last_out", {31'b0, want.last}, {31'b0, rsp_tlast});
            end
         end
         if (req_tvalid && req_tready) begin
            predict_set(req_tdata, req_tlast, in_count);
            in_count <= in_count + 1;
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (in_count == stim_q.size());
      wait (sorted_pending.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && sorted_pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/sso_pkg.sv
sv/sso_ram.sv
sv/sso_dp.sv
sv/sso_ctrl.sv
sv/shell_sort_odd_gap.sv
sim/shell_sort_odd_gap_test.sv
